// File: hdl/rsa_pkg.sv
package rsa_pkg;

   // field widths of the item channels
   localparam int SAMPLE_W = 16;
   localparam int RANGE_W  = 17;
   localparam int MEAN_W   = 24;
   localparam int DEV_W    = 25;

   // accumulator widths
   localparam int COUNT_W  = 17;
   localparam int SUM_W    = 33;
   localparam int MAG_W    = 32;
   localparam int SQ_W     = 48;

   // serial multiplier: wide multiplicand, multiplier consumed one bit a cycle
   localparam int MUL_A_W  = 64;
   localparam int MUL_B_W  = 32;

   // serial divider: dividend consumed one bit a cycle
   localparam int DIV_N_W  = 80;
   localparam int DIV_D_W  = 35;

   // serial square root: two radicand bits a cycle
   localparam int RAD_W    = 48;
   localparam int ROOT_W   = RAD_W / 2;

endpackage

// File: hdl/rsa_mul.sv
module rsa_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsa_pkg::MUL_A_W-1:0]      multiplicand,
   input  logic [rsa_pkg::MUL_B_W-1:0]      multiplier,
   output logic                             done,
   output logic [rsa_pkg::MUL_A_W-1:0]      product
);

   localparam int CNT_W = $clog2(rsa_pkg::MUL_B_W);

   logic [rsa_pkg::MUL_A_W-1:0] acc_ff, acc_in;
   logic [rsa_pkg::MUL_A_W-1:0] a_ff, a_in;
   logic [rsa_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   // shift and add, one multiplier bit per cycle
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = multiplicand;
         b_in    = multiplier;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[rsa_pkg::MUL_A_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[rsa_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(rsa_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: hdl/rsa_div.sv
module rsa_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsa_pkg::DIV_N_W-1:0]      dividend,
   input  logic [rsa_pkg::DIV_D_W-1:0]      divisor,
   output logic                             done,
   output logic [rsa_pkg::DIV_N_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(rsa_pkg::DIV_N_W);
   localparam int REM_W = rsa_pkg::DIV_D_W + 1;

   logic [rsa_pkg::DIV_N_W-1:0] quo_ff, quo_in;
   logic [rsa_pkg::DIV_D_W-1:0] den_ff, den_in;
   logic [rsa_pkg::DIV_D_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            trial;
   logic                        fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[rsa_pkg::DIV_N_W-1]};
      fits    = trial >= {1'b0, den_ff};
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rsa_pkg::DIV_D_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[rsa_pkg::DIV_D_W-1:0];
         end
         quo_in = {quo_ff[rsa_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(rsa_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/rsa_sqrt.sv
module rsa_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsa_pkg::RAD_W-1:0]        radicand,
   output logic                             done,
   output logic [rsa_pkg::ROOT_W-1:0]       root
);

   localparam int CNT_W = $clog2(rsa_pkg::ROOT_W);
   localparam int REM_W = rsa_pkg::ROOT_W + 3;

   logic [rsa_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [rsa_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [REM_W-1:0]           partial;
   logic [REM_W-1:0]           trial;

   // digit by digit root, two radicand bits per cycle
   always_comb begin
      partial = {rem_ff[REM_W-3:0], rad_ff[rsa_pkg::RAD_W-1:rsa_pkg::RAD_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (partial >= trial) begin
            rem_in  = partial - trial;
            root_in = {root_ff[rsa_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = partial;
            root_in = {root_ff[rsa_pkg::ROOT_W-2:0], 1'b0};
         end
         rad_in = {rad_ff[rsa_pkg::RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(rsa_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: hdl/row_statistics_accumulator.sv
// Row statistics accumulator. Signed samples arrive on the req channel, one item per
// cycle while the block is idle, and are folded into count, minimum, maximum, sum and
// sum of squares. An item with req_tlast set closes the row: the block then stops
// taking items while a shared bit-serial multiplier forms n*sum_sq, sum^2 and n^2, a
// bit-serial divider forms the rounded mean and the variance and a serial root unit
// gives the deviation; the result is then loaded, and only then is the next item
// taken. An empty row goes straight to loading its result; either waits longer while
// the previous result still waits on rsp_tready. Mean and deviation carry
// FRACTION_BITS fraction bits; an empty row returns -1 in every field with row_empty
// set in rsp_tuser. Samples beyond MAX_ROW_LENGTH in one row are dropped.
module row_statistics_accumulator #(
   parameter int MAX_ROW_LENGTH = 65536,
   parameter int SAMPLE_BITS    = 16,
   parameter int FRACTION_BITS  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // sample[15:0]
   input  logic         req_tlast,   // row_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // row_min[15:0], row_max[31:16], row_range[48:32],
                                     // row_mean[72:49], row_deviation[97:73], zero fill
   output logic         rsp_tuser    // row_empty
);

   localparam int SW = rsa_pkg::SAMPLE_W;
   localparam int CW = rsa_pkg::COUNT_W;
   localparam int RANGE_W_L = rsa_pkg::RANGE_W;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_ROW_LENGTH);
   localparam logic [SW-1:0] MIN_RESET = SW'((32'd1 << (SAMPLE_BITS - 1)) - 32'd1);
   localparam logic [SW-1:0] MAX_RESET = SW'(-(32'sd1 <<< (SAMPLE_BITS - 1)));
   localparam logic [rsa_pkg::DEV_W-1:0] NEG_ONE_FX =
      ~((rsa_pkg::DEV_W'(1) << FRACTION_BITS) - rsa_pkg::DEV_W'(1));

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_NS2  = 3'd1;
   localparam logic [2:0] ST_MUL_MM   = 3'd2;
   localparam logic [2:0] ST_MUL_NN   = 3'd3;
   localparam logic [2:0] ST_DIV_MEAN = 3'd4;
   localparam logic [2:0] ST_DIV_VAR  = 3'd5;
   localparam logic [2:0] ST_ROOT     = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   logic [2:0]  state_ff, state_in;

   // running accumulators
   logic [CW-1:0]               count_ff, count_in;
   logic signed [SW-1:0]        min_ff, min_in;
   logic signed [SW-1:0]        max_ff, max_in;
   logic signed [rsa_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [rsa_pkg::SQ_W-1:0]    sq_ff, sq_in;

   // row snapshot and intermediate results
   logic [CW-1:0]               fin_n_ff, fin_n_in;
   logic [rsa_pkg::MAG_W-1:0]   fin_mag_ff, fin_mag_in;
   logic                        fin_neg_ff, fin_neg_in;
   logic [rsa_pkg::SQ_W-1:0]    fin_sq_ff, fin_sq_in;
   logic [SW-1:0]               fin_min_ff, fin_min_in;
   logic [SW-1:0]               fin_max_ff, fin_max_in;
   logic                        fin_empty_ff, fin_empty_in;
   logic [rsa_pkg::MUL_A_W-1:0] p_ns2_ff, p_ns2_in;
   logic [rsa_pkg::MUL_A_W-1:0] p_mm_ff, p_mm_in;
   logic [2*CW-1:0]             p_nn_ff, p_nn_in;
   logic [rsa_pkg::MEAN_W-1:0]  q_ff, q_in;
   logic [rsa_pkg::DEV_W-1:0]   dev_ff, dev_in;

   logic        mul_start_ff, mul_start_in;
   logic        div_start_ff, div_start_in;
   logic        sqrt_start_ff, sqrt_start_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [103:0]  rsp_data_ff, rsp_data_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic signed [SW-1:0]        smp;
   logic [2*SW-1:0]             smp_sq;
   logic                        accept;
   logic [rsa_pkg::SUM_W-1:0]   neg_sum;

   logic [rsa_pkg::MUL_A_W-1:0] mul_a;
   logic [rsa_pkg::MUL_B_W-1:0] mul_b;
   logic                        mul_done;
   logic [rsa_pkg::MUL_A_W-1:0] mul_p;
   logic [rsa_pkg::DIV_N_W-1:0] div_n;
   logic [rsa_pkg::DIV_D_W-1:0] div_d;
   logic                        div_done;
   logic [rsa_pkg::DIV_N_W-1:0] div_q;
   logic                        sqrt_done;
   logic [rsa_pkg::ROOT_W-1:0]  sqrt_root;
   logic [rsa_pkg::MUL_A_W-1:0] var_num;
   logic [rsa_pkg::MEAN_W-1:0]  mean_out;
   logic [RANGE_W_L-1:0]        range_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // sample taken from its low bits, sign extended
   assign smp    = $signed(req_tdata << (SW - SAMPLE_BITS)) >>> (SW - SAMPLE_BITS);
   assign smp_sq = $unsigned((2*SW)'(smp) * (2*SW)'(smp));
   assign neg_sum = rsa_pkg::SUM_W'(-sum_ff);

   // accumulate samples, snapshot and clear at row end
   always_comb begin
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      fin_n_in   = fin_n_ff;
      fin_mag_in = fin_mag_ff;
      fin_neg_in = fin_neg_ff;
      fin_sq_in  = fin_sq_ff;
      fin_min_in = fin_min_ff;
      fin_max_in = fin_max_ff;
      fin_empty_in = fin_empty_ff;
      if (accept && !req_tlast) begin
         if (count_ff < MAX_LEN) begin
            if (smp < min_ff) min_in = smp;
            if (smp > max_ff) max_in = smp;
            sum_in   = sum_ff + rsa_pkg::SUM_W'(smp);
            sq_in    = sq_ff + rsa_pkg::SQ_W'(smp_sq);
            count_in = count_ff + CW'(1);
         end
      end else if (accept) begin
         fin_n_in     = count_ff;
         fin_neg_in   = sum_ff[rsa_pkg::SUM_W-1];
         fin_mag_in   = sum_ff[rsa_pkg::SUM_W-1] ? neg_sum[rsa_pkg::MAG_W-1:0]
                                                 : sum_ff[rsa_pkg::MAG_W-1:0];
         fin_sq_in    = sq_ff;
         fin_min_in   = min_ff;
         fin_max_in   = max_ff;
         fin_empty_in = (count_ff == '0);
         count_in = '0;
         min_in   = MIN_RESET;
         max_in   = MAX_RESET;
         sum_in   = '0;
         sq_in    = '0;
      end
   end

   // operand selection for the shared serial units
   assign var_num = p_ns2_ff - p_mm_ff;
   always_comb begin
      unique case (state_ff)
         ST_MUL_NS2: begin
            mul_a = rsa_pkg::MUL_A_W'(fin_sq_ff);
            mul_b = rsa_pkg::MUL_B_W'(fin_n_ff);
         end
         ST_MUL_MM: begin
            mul_a = rsa_pkg::MUL_A_W'(fin_mag_ff);
            mul_b = fin_mag_ff;
         end
         default: begin
            mul_a = rsa_pkg::MUL_A_W'(fin_n_ff);
            mul_b = rsa_pkg::MUL_B_W'(fin_n_ff);
         end
      endcase
      if (state_ff == ST_DIV_MEAN) begin
         div_n = (rsa_pkg::DIV_N_W'(fin_mag_ff) << (FRACTION_BITS + 1))
                 + rsa_pkg::DIV_N_W'(fin_n_ff);
         div_d = rsa_pkg::DIV_D_W'({fin_n_ff, 1'b0});
      end else begin
         div_n = rsa_pkg::DIV_N_W'(var_num) << (2 * FRACTION_BITS);
         div_d = rsa_pkg::DIV_D_W'(p_nn_ff);
      end
   end

   assign mean_out  = fin_neg_ff ? rsa_pkg::MEAN_W'(-q_ff) : q_ff;
   assign range_out = RANGE_W_L'($signed(fin_max_ff)) - RANGE_W_L'($signed(fin_min_ff));

   // row end sequencer
   always_comb begin
      state_in      = state_ff;
      mul_start_in  = 1'b0;
      div_start_in  = 1'b0;
      sqrt_start_in = 1'b0;
      p_ns2_in      = p_ns2_ff;
      p_mm_in       = p_mm_ff;
      p_nn_in       = p_nn_ff;
      q_in          = q_ff;
      dev_in        = dev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               if (count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in     = ST_MUL_NS2;
                  mul_start_in = 1'b1;
               end
            end
         end
         ST_MUL_NS2: begin
            if (mul_done) begin
               p_ns2_in     = mul_p;
               state_in     = ST_MUL_MM;
               mul_start_in = 1'b1;
            end
         end
         ST_MUL_MM: begin
            if (mul_done) begin
               p_mm_in      = mul_p;
               state_in     = ST_MUL_NN;
               mul_start_in = 1'b1;
            end
         end
         ST_MUL_NN: begin
            if (mul_done) begin
               p_nn_in      = mul_p[2*CW-1:0];
               state_in     = ST_DIV_MEAN;
               div_start_in = 1'b1;
            end
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               q_in         = div_q[rsa_pkg::MEAN_W-1:0];
               state_in     = ST_DIV_VAR;
               div_start_in = 1'b1;
            end
         end
         ST_DIV_VAR: begin
            if (div_done) begin
               state_in      = ST_ROOT;
               sqrt_start_in = 1'b1;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               dev_in   = rsa_pkg::DEV_W'(sqrt_root);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = fin_empty_ff;
               if (fin_empty_ff) begin
                  rsp_data_in = {6'b0, NEG_ONE_FX, NEG_ONE_FX[rsa_pkg::MEAN_W-1:0],
                                 {RANGE_W_L{1'b1}}, {SW{1'b1}}, {SW{1'b1}}};
               end else begin
                  rsp_data_in = {6'b0, dev_ff, mean_out, range_out, fin_max_ff, fin_min_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fin_n_ff     <= fin_n_in;
      fin_mag_ff   <= fin_mag_in;
      fin_neg_ff   <= fin_neg_in;
      fin_sq_ff    <= fin_sq_in;
      fin_min_ff   <= fin_min_in;
      fin_max_ff   <= fin_max_in;
      fin_empty_ff <= fin_empty_in;
      p_ns2_ff     <= p_ns2_in;
      p_mm_ff      <= p_mm_in;
      p_nn_ff      <= p_nn_in;
      q_ff         <= q_in;
      dev_ff       <= dev_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         min_ff        <= MIN_RESET;
         max_ff        <= MAX_RESET;
         sum_ff        <= '0;
         sq_ff         <= '0;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         sum_ff        <= sum_in;
         sq_ff         <= sq_in;
         mul_start_ff  <= mul_start_in;
         div_start_ff  <= div_start_in;
         sqrt_start_ff <= sqrt_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // serial arithmetic units
   rsa_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start_ff),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .done         (mul_done),
      .product      (mul_p)
   );

   rsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   rsa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (div_q[rsa_pkg::RAD_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

// File: verif/row_statistics_accumulator_tb.sv
`timescale 1ns / 1ps

module row_statistics_accumulator_tb;

   localparam int MAX_ROW_LENGTH = 65536;
   localparam int FRACTION_BITS  = 8;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct packed {
      logic signed [rsa_pkg::SAMPLE_W-1:0] row_min;
      logic signed [rsa_pkg::SAMPLE_W-1:0] row_max;
      logic signed [rsa_pkg::RANGE_W-1:0]  row_range;
      logic signed [rsa_pkg::MEAN_W-1:0]   row_mean;
      logic signed [rsa_pkg::DEV_W-1:0]    row_deviation;
      logic                                row_empty;
   } row_stats_type;

   typedef struct {
      logic [15:0]   sample;
      logic          row_end;
      logic          typed;
      row_stats_type stats;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;

   row_statistics_accumulator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always #1 clock = ~clock;

   // predictor state
   int unsigned       acc_count;
   int                acc_min;
   int                acc_max;
   longint            acc_sum;
   bit [63:0]         acc_squares;
   row_stats_type     pending_stats[$];
   stim_row_type      directed[$];
   int                idle_pct = 38;
   int                mismatches = 0;
   int                cycles = 0;

   function automatic void clear_row();
      acc_count   = 0;
      acc_min     = 32767;
      acc_max     = -32768;
      acc_sum     = 0;
      acc_squares = 0;
   endfunction

   function automatic bit [63:0] isqrt(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // fold one accepted item; returns 1 with the row statistics on a row end
   function automatic bit predict_item(logic [15:0] sample, logic row_end,
                                       output row_stats_type st);
      int        s;
      bit [63:0] n, mag, q, num, den, vq, vr, root;
      longint    mean;
      st = '0;
      if (!row_end) begin
         s = $signed(sample);
         if (acc_count >= MAX_ROW_LENGTH) return 0;
         if (s < acc_min) acc_min = s;
         if (s > acc_max) acc_max = s;
         acc_sum     = acc_sum + s;
         acc_squares = acc_squares + 64'(longint'(s) * longint'(s));
         acc_count++;
         return 0;
      end
      if (acc_count == 0) begin
         st.row_min       = '1;
         st.row_max       = '1;
         st.row_range     = '1;
         st.row_mean      = rsa_pkg::MEAN_W'(-(1 << FRACTION_BITS));
         st.row_deviation = rsa_pkg::DEV_W'(-(1 << FRACTION_BITS));
         st.row_empty     = 1'b1;
      end else begin
         n    = acc_count;
         mag  = (acc_sum < 0) ? 64'(-acc_sum) : 64'(acc_sum);
         q    = ((mag << (FRACTION_BITS + 1)) + n) / (2 * n);
         mean = (acc_sum < 0) ? -longint'(q) : longint'(q);
         num  = n * acc_squares - mag * mag;
         den  = n * n;
         vq   = num / den;
         vr   = num % den;
         for (int i = 0; i < 2 * FRACTION_BITS; i++) begin
            vr = vr << 1;
            vq = vq << 1;
            if (vr >= den) begin
               vr = vr - den;
               vq = vq | 64'd1;
            end
         end
         root             = isqrt(vq);
         st.row_min       = acc_min[15:0];
         st.row_max       = acc_max[15:0];
         st.row_range     = 17'(acc_max - acc_min);
         st.row_mean      = mean[rsa_pkg::MEAN_W-1:0];
         st.row_deviation = root[rsa_pkg::DEV_W-1:0];
         st.row_empty     = 1'b0;
      end
      clear_row();
      return 1;
   endfunction

   // drive one item, idling at random first with valid low; valid holds until it is taken
   task automatic send_item(logic [15:0] sample, logic row_end, logic typed = 1'b0,
                            row_stats_type typed_stats = '0);
      row_stats_type st;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         req_tlast  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      if (predict_item(sample, row_end, st))
         pending_stats.push_back(typed ? typed_stats : st);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      unique case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      row_stats_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[48:32],
                rsp_tdata[72:49], rsp_tdata[97:73], rsp_tuser};
         if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row result %h", got);
         end else begin
            want = pending_stats.pop_front();
            if (got.row_min !== want.row_min || got.row_max !== want.row_max ||
                got.row_range !== want.row_range || got.row_mean !== want.row_mean ||
                got.row_deviation !== want.row_deviation ||
                got.row_empty !== want.row_empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"row mismatch (exp/act): min %0d/%0d max %0d/%0d ",
                            "range %0d/%0d mean %0d/%0d dev %0d/%0d empty %0b/%0b"},
                     want.row_min, got.row_min, want.row_max, got.row_max,
                     want.row_range, got.row_range, want.row_mean, got.row_mean,
                     want.row_deviation, got.row_deviation, want.row_empty, got.row_empty);
            end
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      row_stats_type none;
      int            len;
      none = '0;
      clear_row();

      // directed table: typed rows are results readable at a glance
      directed.push_back(stim_row_type'{16'h0000, 1'b1, 1'b1,
                           '{16'hffff, 16'hffff, 17'h1ffff, -24'sd256, -25'sd256, 1'b1}});
      directed.push_back(stim_row_type'{16'hffff, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0000, 1'b1, 1'b1,
                           '{-16'sd1, -16'sd1, 17'd0, -24'sd256, 25'd0, 1'b0}});
      directed.push_back(stim_row_type'{16'h0000, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0000, 1'b1, 1'b1,
                           '{16'd0, 16'd0, 17'd0, 24'd0, 25'd0, 1'b0}});
      directed.push_back(stim_row_type'{16'h7fff, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h8000, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h1234, 1'b1, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0005, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'hfffb, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'hffff, 1'b1, 1'b0, none});
      directed.push_back(stim_row_type'{16'h7fff, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h7fff, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0000, 1'b1, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0000, 1'b1, 1'b1,
                           '{16'hffff, 16'hffff, 17'h1ffff, -24'sd256, -25'sd256, 1'b1}});
      directed.push_back(stim_row_type'{16'h0001, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0002, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h0004, 1'b0, 1'b0, none});
      directed.push_back(stim_row_type'{16'h5555, 1'b1, 1'b0, none});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i])
         send_item(directed[i].sample, directed[i].row_end, directed[i].typed,
                   directed[i].stats);

      // random rows, mostly short, with a stretch of no idling
      for (int item_no = 0; item_no < 730; ) begin
         idle_pct = (item_no >= 300 && item_no < 450) ? 0 : 38;
         len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
         for (int k = 0; k < len; k++) begin
            send_item(pick_sample(), 1'b0);
            item_no++;
         end
         send_item(16'($urandom), 1'b1);
         item_no++;
      end
      idle_pct = 38;
      req_tvalid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_stats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
